// ===== rtl/core/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants for the servo frame deframer
// Field widths, register indexes, parser phase codes and the result record.
// ----------------------------------------------------------------------------
package sfd_pkg;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int SERVO_W = 16;

   // Frame layout
   localparam int PAYLOAD_BYTES = 8;
   localparam int POS_W         = 4;
   localparam int PAYLOAD_W     = PAYLOAD_BYTES * BYTE_W;

   // Configuration port
   localparam int CSR_COUNT   = 2;
   localparam int CSR_INDEX_W = $clog2(CSR_COUNT);
   localparam int CSR_DATA_W  = BYTE_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_MARKER = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_END_MARKER   = CSR_INDEX_W'(1);

   localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'hAA;
   localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'h55;

   // Checksum status codes
   localparam logic STATUS_GOOD     = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   // Parser phase, one-hot
   typedef enum logic [2:0] {
      PHASE_HUNT    = 3'b001,
      PHASE_COLLECT = 3'b010,
      PHASE_END     = 3'b100
   } phase_type;

   // One decoded frame
   typedef struct packed {
      logic               frame_status;
      logic [SERVO_W-1:0] servo_one;
      logic [SERVO_W-1:0] servo_two;
      logic [SERVO_W-1:0] servo_three;
      logic [SERVO_W-1:0] servo_four;
   } result_type;

   // Parser status toward the top level
   typedef struct packed {
      logic awaiting_end;
   } parser_status_type;

endpackage

// ===== rtl/core/sfd_req_if.sv =====
// ----------------------------------------------------------------------------
// sfd_req_if: received byte channel
// Valid/ready channel carrying one received serial byte per transaction.
// ----------------------------------------------------------------------------
interface sfd_req_if;

   logic                      valid;
   logic                      ready;
   logic [sfd_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);

endinterface

// ===== rtl/core/sfd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sfd_rsp_if: decoded frame channel
// Valid/ready channel carrying four servo values and a checksum status.
// ----------------------------------------------------------------------------
interface sfd_rsp_if;

   logic                        valid;
   logic                        ready;
   logic                        frame_status;
   logic [sfd_pkg::SERVO_W-1:0] servo_one;
   logic [sfd_pkg::SERVO_W-1:0] servo_two;
   logic [sfd_pkg::SERVO_W-1:0] servo_three;
   logic [sfd_pkg::SERVO_W-1:0] servo_four;

   modport source (output valid, output frame_status, output servo_one,
                   output servo_two, output servo_three, output servo_four,
                   input ready);
   modport sink   (input valid, input frame_status, input servo_one,
                   input servo_two, input servo_three, input servo_four,
                   output ready);

endinterface

// ===== rtl/core/servo_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// servo_frame_deframer_top: servo command frame deframer
// Parses start marker, eight payload bytes, XOR checksum and end marker from
// a byte stream and delivers four big-endian servo values with a status bit.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                                   handshake
//   req_chan in         rx_byte[7:0]                              valid/ready
//   rsp_chan out        frame_status, servo_one..servo_four[15:0] valid/ready
//   csr_*    in         csr_index[0], csr_wdata[7:0]              csr_wr_en
//
// One byte is taken per cycle while req_chan.ready is high; the parser state
// updates at the edge that takes it, and a closed frame appears at rsp_chan
// on the next cycle. A frame needs eleven bytes, so at most one result per eleven bytes.
// Reset returns the parser to hunting and restores the marker defaults.
// req_chan.ready drops only while a result waits unaccepted and the next byte
// is an end byte that could produce another result.
//
module servo_frame_deframer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [sfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   sfd_req_if.sink                          req_chan,
   sfd_rsp_if.source                        rsp_chan
);

   logic [sfd_pkg::BYTE_W-1:0]   start_marker_ff;
   logic [sfd_pkg::BYTE_W-1:0]   end_marker_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   sfd_pkg::result_type          rsp_data_ff;
   sfd_pkg::result_type          frame_result;
   sfd_pkg::parser_status_type   parser_status;
   logic                         frame_emit;
   logic                         byte_accept;
   logic                         out_blocked;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= sfd_pkg::START_MARKER_RESET;
         end_marker_ff   <= sfd_pkg::END_MARKER_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sfd_pkg::CSR_START_MARKER: start_marker_ff <= csr_wdata;
            sfd_pkg::CSR_END_MARKER:   end_marker_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Hold input while a waiting result could be overwritten
   assign out_blocked    = rsp_valid_ff && !rsp_chan.ready;
   assign req_chan.ready = !(out_blocked && parser_status.awaiting_end);
   assign byte_accept    = req_chan.valid && req_chan.ready;

   sfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_accept  (byte_accept),
      .rx_byte      (req_chan.rx_byte),
      .start_marker (start_marker_ff),
      .end_marker   (end_marker_ff),
      .frame_emit   (frame_emit),
      .frame_result (frame_result),
      .status       (parser_status)
   );

   // Result register
   assign rsp_valid_in = frame_emit || out_blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_emit) begin
         rsp_data_ff <= frame_result;
      end
   end

   // Drive the result transaction
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.frame_status = rsp_data_ff.frame_status;
   assign rsp_chan.servo_one    = rsp_data_ff.servo_one;
   assign rsp_chan.servo_two    = rsp_data_ff.servo_two;
   assign rsp_chan.servo_three  = rsp_data_ff.servo_three;
   assign rsp_chan.servo_four   = rsp_data_ff.servo_four;

endmodule

// ===== rtl/core/sfd_parser.sv =====
// ----------------------------------------------------------------------------
// sfd_parser: frame parser state machine
// Hunts for the start marker, collects payload and checksum, checks the end
// marker and flags a decoded frame in the cycle its end byte is taken.
// ----------------------------------------------------------------------------
module sfd_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         byte_accept,
   input  logic [sfd_pkg::BYTE_W-1:0]   rx_byte,
   input  logic [sfd_pkg::BYTE_W-1:0]   start_marker,
   input  logic [sfd_pkg::BYTE_W-1:0]   end_marker,
   output logic                         frame_emit,
   output sfd_pkg::result_type          frame_result,
   output sfd_pkg::parser_status_type   status
);

   sfd_pkg::phase_type               phase_ff,   phase_in;
   logic [sfd_pkg::POS_W-1:0]        pos_ff,     pos_in;
   logic [sfd_pkg::BYTE_W-1:0]       xor_ff,     xor_in;
   logic [sfd_pkg::PAYLOAD_W-1:0]    payload_ff, payload_in;
   logic [sfd_pkg::BYTE_W-1:0]       check_ff,   check_in;

   // Next state for one accepted byte
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      xor_in     = xor_ff;
      payload_in = payload_ff;
      check_in   = check_ff;
      frame_emit = 1'b0;
      unique case (phase_ff)
         sfd_pkg::PHASE_COLLECT: begin
            if (byte_accept) begin
               pos_in = pos_ff + sfd_pkg::POS_W'(1);
               if (pos_ff < sfd_pkg::POS_W'(sfd_pkg::PAYLOAD_BYTES)) begin
                  payload_in = {payload_ff[sfd_pkg::PAYLOAD_W-sfd_pkg::BYTE_W-1:0],
                                rx_byte};
                  xor_in     = xor_ff ^ rx_byte;
               end else begin
                  check_in = rx_byte;
                  phase_in = sfd_pkg::PHASE_END;
               end
            end
         end
         sfd_pkg::PHASE_END: begin
            if (byte_accept) begin
               frame_emit = (rx_byte == end_marker);
               phase_in   = sfd_pkg::PHASE_HUNT;
               pos_in     = '0;
            end
         end
         default: begin
            // Hunting, and any code that cannot arise
            if (byte_accept) begin
               phase_in = sfd_pkg::PHASE_HUNT;
               if (rx_byte == start_marker) begin
                  phase_in = sfd_pkg::PHASE_COLLECT;
                  pos_in   = '0;
                  xor_in   = '0;
               end
            end
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfd_pkg::PHASE_HUNT;
         pos_ff   <= '0;
         xor_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         xor_ff   <= xor_in;
      end
   end

   // Payload and checksum capture
   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      check_ff   <= check_in;
   end

   // Decode the held frame
   always_comb begin
      frame_result.frame_status = (xor_ff == check_ff) ? sfd_pkg::STATUS_GOOD
                                                       : sfd_pkg::STATUS_MISMATCH;
      frame_result.servo_one    = payload_ff[63:48];
      frame_result.servo_two    = payload_ff[47:32];
      frame_result.servo_three  = payload_ff[31:16];
      frame_result.servo_four   = payload_ff[15:0];
      status.awaiting_end       = (phase_ff == sfd_pkg::PHASE_END);
   end

endmodule
